// ===== src/gnhs_pkg.sv =====
package gnhs_pkg;

    // fixed field widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int WIN_W      = 16;
    localparam int LIMIT_W    = 10;
    localparam int SCORE_W    = 32;
    localparam int SLOT_W     = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIT_LIMIT   = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;         // capture candidate, restart scan
        logic scan;         // walk the kept table
        logic fin_ignore;   // post an ignored verdict
        logic fin_scan;     // post verdict of the scan, store on accept
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic limit_over;
        logic scan_done;
    } dp_status_t;

endpackage

// ===== src/gnhs_ctrl.sv =====
module gnhs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  gnhs_pkg::dp_status_t status,
    output gnhs_pkg::dp_cmd_t    cmd
);
    import gnhs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_LIMIT = 3'b010,
        S_SCAN  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LIMIT;
                end
            end
            S_LIMIT:
            begin
                if (!status.limit_over)
                begin
                    state_next = S_SCAN;
                end
                else if (out_free)
                begin
                    cmd.fin_ignore = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done && out_free)
                begin
                    cmd.fin_scan   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/gnhs_datapath.sv =====
module gnhs_datapath #(
    parameter int MAX_HITS = 256,
    parameter int POS_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_en,
    input  logic [gnhs_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [gnhs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 first,
    input  logic [POS_BITS-1:0]                  start_a,
    input  logic [POS_BITS-1:0]                  end_a,
    input  logic [POS_BITS-1:0]                  start_b,
    input  logic [POS_BITS-1:0]                  end_b,
    input  logic signed [gnhs_pkg::SCORE_W-1:0]  cand_score,
    output logic                                 accepted,
    output logic [gnhs_pkg::SLOT_W-1:0]          hit_slot,
    output logic                                 ignored,
    output logic                                 table_full,
    output logic signed [gnhs_pkg::SCORE_W-1:0]  hit_score,
    input  gnhs_pkg::dp_cmd_t                    cmd,
    output gnhs_pkg::dp_status_t                 status
);
    import gnhs_pkg::*;

    localparam int CNT_W   = $clog2(MAX_HITS + 1);
    localparam int ADDR_W  = $clog2(MAX_HITS);
    localparam int ENTRY_W = 4 * POS_BITS;
    localparam int SUM_W   = ((POS_BITS > WIN_W) ? POS_BITS : WIN_W) + 1;
    localparam int LIM_W   = LIMIT_W - 1;
    localparam int CMP_W   = ((CNT_W > LIM_W) ? CNT_W : LIM_W);

    // configuration
    logic               border_mode_reg;
    logic [WIN_W-1:0]   window_reg;
    logic [LIMIT_W-1:0] hit_limit_reg;

    // candidate
    logic [POS_BITS-1:0]       sa_reg, ea_reg, sb_reg, eb_reg;
    logic signed [SCORE_W-1:0] score_reg;

    // table and scan control
    logic [ENTRY_W-1:0] mem [MAX_HITS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               rd_vld_reg, rd_vld_next;
    logic               hit_reg, hit_next;

    // results
    logic                      accepted_reg, ignored_reg, full_reg;
    logic [SLOT_W-1:0]         slot_reg;
    logic signed [SCORE_W-1:0] hit_score_reg;

    logic [POS_BITS-1:0] csa, cea, csb, ceb;
    logic [SUM_W-1:0]    w_ext;
    logic                collide_now;
    logic                more;
    logic                issue;
    logic                is_full;
    logic                do_write;
    logic [CMP_W-1:0]    cnt_cmp, lim_cmp;
    logic [SLOT_W+CNT_W-1:0] slot_ext;

    assign csa   = rd_data_reg[4*POS_BITS-1:3*POS_BITS];
    assign cea   = rd_data_reg[3*POS_BITS-1:2*POS_BITS];
    assign csb   = rd_data_reg[2*POS_BITS-1:POS_BITS];
    assign ceb   = rd_data_reg[POS_BITS-1:0];
    assign w_ext = SUM_W'(window_reg);

    // border test rearranged as sums so nothing goes negative
    always_comb
    begin
        logic border_hit;
        logic overlap_hit;
        border_hit = (SUM_W'(sa_reg) < SUM_W'(csa) + w_ext)
                  && (SUM_W'(csa) < SUM_W'(ea_reg) + w_ext)
                  && (SUM_W'(sb_reg) < SUM_W'(csb) + w_ext)
                  && (SUM_W'(csb) < SUM_W'(eb_reg) + w_ext);
        overlap_hit = (sa_reg <= cea) && (ea_reg >= csa)
                   && (sb_reg <= ceb) && (eb_reg >= csb);
        collide_now = rd_vld_reg && (border_mode_reg ? border_hit : overlap_hit);
    end

    assign more     = (idx_reg < count_reg);
    assign issue    = cmd.scan && !hit_reg && !collide_now && more;
    assign is_full  = (count_reg == CNT_W'(MAX_HITS));
    assign do_write = cmd.fin_scan && !hit_reg && !is_full;

    assign cnt_cmp  = CMP_W'(count_reg);
    assign lim_cmp  = CMP_W'(hit_limit_reg[LIM_W-1:0]);
    assign slot_ext = {{SLOT_W{1'b0}}, count_reg};

    assign status.limit_over = !hit_limit_reg[LIMIT_W-1] && (cnt_cmp > lim_cmp);
    assign status.scan_done  = hit_reg || (!more && !rd_vld_reg);

    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        rd_vld_next = 1'b0;
        hit_next    = hit_reg;
        if (cmd.load)
        begin
            idx_next = '0;
            hit_next = 1'b0;
            if (first)
            begin
                count_next = '0;
            end
        end
        else
        begin
            if (issue)
            begin
                idx_next    = idx_reg + CNT_W'(1);
                rd_vld_next = 1'b1;
            end
            if (collide_now)
            begin
                hit_next = 1'b1;
            end
            if (do_write)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            border_mode_reg <= 1'b0;
            window_reg      <= '0;
            hit_limit_reg   <= '1;
            count_reg       <= '0;
            idx_reg         <= '0;
            rd_vld_reg      <= 1'b0;
            hit_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_en)
            begin
                case (cfg_idx)
                    REG_BORDER_MODE: border_mode_reg <= cfg_data[0];
                    REG_WINDOW:      window_reg      <= cfg_data[WIN_W-1:0];
                    REG_HIT_LIMIT:   hit_limit_reg   <= cfg_data[LIMIT_W-1:0];
                    default:         ;
                endcase
            end
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            rd_vld_reg <= rd_vld_next;
            hit_reg    <= hit_next;
        end
    end

    // kept table, one read and one write port
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[count_reg[ADDR_W-1:0]] <= {sa_reg, ea_reg, sb_reg, eb_reg};
        end
        rd_data_reg <= mem[idx_reg[ADDR_W-1:0]];
    end

    // candidate and result words
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sa_reg    <= start_a;
            ea_reg    <= end_a;
            sb_reg    <= start_b;
            eb_reg    <= end_b;
            score_reg <= cand_score;
        end
        if (cmd.fin_ignore)
        begin
            accepted_reg  <= 1'b0;
            slot_reg      <= '0;
            ignored_reg   <= 1'b1;
            full_reg      <= 1'b0;
            hit_score_reg <= score_reg;
        end
        else if (cmd.fin_scan)
        begin
            accepted_reg  <= do_write;
            slot_reg      <= do_write ? slot_ext[SLOT_W-1:0] : '0;
            ignored_reg   <= 1'b0;
            full_reg      <= !hit_reg && is_full;
            hit_score_reg <= score_reg;
        end
    end

    assign accepted   = accepted_reg;
    assign hit_slot   = slot_reg;
    assign ignored    = ignored_reg;
    assign table_full = full_reg;
    assign hit_score  = hit_score_reg;

endmodule

// ===== src/greedy_nonoverlap_hit_selector_unit.sv =====
// channel   handshake               payload
// -------   ---------------------   ------------------------------------------------
// in        in_valid / in_ready     first, start_a, end_a, start_b, end_b, cand_score
// out       out_valid / out_ready   accepted, hit_slot, ignored, table_full, hit_score
// cfg       cfg_en (no wait)        cfg_idx, cfg_data
//
// a word scans the kept hits, read one per cycle through a single read port; the
// scan ends early on a collision
// an ignored word skips the scan, the table is not read
// rst_n clears count, scan control and config; the table needs no clearing pass
// in_ready is high whenever the controller is idle, even while a result waits;
// a finished verdict holds in the scan or limit check until the output register is free

module greedy_nonoverlap_hit_selector_unit #(
    parameter int MAX_HITS = 256,
    parameter int POS_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration writes
    input  logic                                 cfg_en,
    input  logic [gnhs_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [gnhs_pkg::CFG_DATA_W-1:0]      cfg_data,
    // candidate words
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 first,
    input  logic [POS_BITS-1:0]                  start_a,
    input  logic [POS_BITS-1:0]                  end_a,
    input  logic [POS_BITS-1:0]                  start_b,
    input  logic [POS_BITS-1:0]                  end_b,
    input  logic signed [gnhs_pkg::SCORE_W-1:0]  cand_score,
    // verdict words
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 accepted,
    output logic [gnhs_pkg::SLOT_W-1:0]          hit_slot,
    output logic                                 ignored,
    output logic                                 table_full,
    output logic signed [gnhs_pkg::SCORE_W-1:0]  hit_score
);
    import gnhs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencing: idle, limit check, table scan
    gnhs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // config registers, kept table, compare logic and result register
    gnhs_datapath #(
        .MAX_HITS (MAX_HITS),
        .POS_BITS (POS_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_en     (cfg_en),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .first      (first),
        .start_a    (start_a),
        .end_a      (end_a),
        .start_b    (start_b),
        .end_b      (end_b),
        .cand_score (cand_score),
        .accepted   (accepted),
        .hit_slot   (hit_slot),
        .ignored    (ignored),
        .table_full (table_full),
        .hit_score  (hit_score),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

// ===== dv/gnhs_verdict_checker.sv =====
`timescale 1ns / 1ps

module gnhs_verdict_checker #(
    parameter int MAX_HITS = 256,
    parameter int POS_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_en,
    input  logic [gnhs_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [gnhs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic                                 first,
    input  logic [POS_BITS-1:0]                  start_a,
    input  logic [POS_BITS-1:0]                  end_a,
    input  logic [POS_BITS-1:0]                  start_b,
    input  logic [POS_BITS-1:0]                  end_b,
    input  logic signed [gnhs_pkg::SCORE_W-1:0]  cand_score,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic                                 accepted,
    input  logic [gnhs_pkg::SLOT_W-1:0]          hit_slot,
    input  logic                                 ignored,
    input  logic                                 table_full,
    input  logic signed [gnhs_pkg::SCORE_W-1:0]  hit_score,
    output int                                   mismatch_count,
    output int                                   verdicts_due
);

    import gnhs_pkg::*;

    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic                accepted;
        logic [SLOT_W-1:0]   slot;
        logic                ignored;
        logic                table_full;
        logic [SCORE_W-1:0]  score;
    } verdict_t;

    // kept hit table and running count
    logic [POS_BITS-1:0] kept_sa [MAX_HITS];
    logic [POS_BITS-1:0] kept_ea [MAX_HITS];
    logic [POS_BITS-1:0] kept_sb [MAX_HITS];
    logic [POS_BITS-1:0] kept_eb [MAX_HITS];
    int                  kept_total;

    logic                       border_on;
    logic [WIN_W-1:0]           widen;
    logic signed [LIMIT_W-1:0]  limit_reg;

    verdict_t verdicts_pending[$];

    task automatic log_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("%0t checker: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic bit overlaps_kept(input int idx, input longint sa, input longint ea,
                                         input longint sb, input longint eb);
        longint csa, cea, csb, ceb, w;
        csa = longint'(kept_sa[idx]);
        cea = longint'(kept_ea[idx]);
        csb = longint'(kept_sb[idx]);
        ceb = longint'(kept_eb[idx]);
        w   = longint'(widen);
        // widened bounds at full width, may go negative
        if (border_on)
            return (sa - w < csa) && (csa < ea + w) && (sb - w < csb) && (csb < eb + w);
        return (sa <= cea) && (ea >= csa) && (sb <= ceb) && (eb >= csb);
    endfunction

    function automatic verdict_t select_hit();
        verdict_t v;
        bit       clash;
        int       lim;
        int       i;
        v = '0;
        v.score = cand_score;
        if (first)
            kept_total = 0;
        lim = int'(limit_reg);
        if (lim > -1 && kept_total > lim) begin
            v.ignored = 1'b1;
            return v;
        end
        clash = 1'b0;
        for (i = 0; i < kept_total && i < MAX_HITS; i++)
            if (!clash && overlaps_kept(i, longint'(start_a), longint'(end_a),
                                        longint'(start_b), longint'(end_b)))
                clash = 1'b1;
        if (clash)
            return v;
        if (kept_total >= MAX_HITS) begin
            v.table_full = 1'b1;
            return v;
        end
        kept_sa[kept_total] = start_a;
        kept_ea[kept_total] = end_a;
        kept_sb[kept_total] = start_b;
        kept_eb[kept_total] = end_b;
        v.accepted = 1'b1;
        v.slot     = kept_total[SLOT_W-1:0];
        kept_total++;
        return v;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        verdict_t want;
        if (!rst_n) begin
            kept_total = 0;
            border_on  = 1'b0;
            widen      = '0;
            limit_reg  = '1;
            verdicts_pending.delete();
            mismatch_count = 0;
            verdicts_due   = 0;
        end else begin
            // a verdict leaving now cannot belong to a word entering now
            if (out_valid && out_ready) begin
                if (verdicts_pending.size() == 0) begin
                    log_mismatch($sformatf("verdict word with none expected, score %0d",
                                           hit_score));
                end else begin
                    want = verdicts_pending.pop_front();
                    if (accepted !== want.accepted)
                        log_mismatch($sformatf("accepted %b want %b, score %0d",
                                               accepted, want.accepted, $signed(want.score)));
                    if (hit_slot !== want.slot)
                        log_mismatch($sformatf("hit_slot %0d want %0d, score %0d",
                                               hit_slot, want.slot, $signed(want.score)));
                    if (ignored !== want.ignored)
                        log_mismatch($sformatf("ignored %b want %b, score %0d",
                                               ignored, want.ignored, $signed(want.score)));
                    if (table_full !== want.table_full)
                        log_mismatch($sformatf("table_full %b want %b, score %0d",
                                               table_full, want.table_full,
                                               $signed(want.score)));
                    if (hit_score !== want.score)
                        log_mismatch($sformatf("hit_score %0d want %0d",
                                               hit_score, $signed(want.score)));
                end
            end
            if (cfg_en)
                case (cfg_idx)
                    REG_BORDER_MODE: border_on = cfg_data[0];
                    REG_WINDOW:      widen     = cfg_data[WIN_W-1:0];
                    REG_HIT_LIMIT:   limit_reg = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            if (in_valid && in_ready)
                verdicts_pending.push_back(select_hit());
            verdicts_due = verdicts_pending.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import gnhs_pkg::*;

    localparam int MAX_HITS      = 256;
    localparam int POS_BITS      = 16;
    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_WORDS  = 1160;
    // slowest word is a full table scan
    localparam int SETTLE_CYCLES = 300;
    // receiver hold-off long enough to back the block up to its input
    localparam int HOLD_CYCLES   = 400;
    // no handshake for this long means the block is stuck
    localparam int STALL_LIMIT   = 5000;

    // positions clear of any filled table entry, in both modes
    localparam logic [15:0] FAR_LO = 16'd65500;
    localparam logic [15:0] FAR_HI = 16'd65530;

    // receiver ready patterns
    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PULSE} rx_pattern_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_en;
    logic [CFG_IDX_W-1:0]        cfg_idx;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic                        first;
    logic [POS_BITS-1:0]         start_a;
    logic [POS_BITS-1:0]         end_a;
    logic [POS_BITS-1:0]         start_b;
    logic [POS_BITS-1:0]         end_b;
    logic signed [SCORE_W-1:0]   cand_score;
    logic                        out_valid;
    logic                        out_ready;
    logic                        accepted;
    logic [SLOT_W-1:0]           hit_slot;
    logic                        ignored;
    logic                        table_full;
    logic signed [SCORE_W-1:0]   hit_score;

    int mismatch_count;
    int verdicts_due;

    // sender bookkeeping
    int words_sent    = 0;
    int burst_left    = 0;
    // bumped by the stimulus, served by the receiver
    int hold_requests = 0;

    always #(HALF_PERIOD) clk = ~clk;

    greedy_nonoverlap_hit_selector_unit #(
        .MAX_HITS (MAX_HITS),
        .POS_BITS (POS_BITS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_en     (cfg_en),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .first      (first),
        .start_a    (start_a),
        .end_a      (end_a),
        .start_b    (start_b),
        .end_b      (end_b),
        .cand_score (cand_score),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .accepted   (accepted),
        .hit_slot   (hit_slot),
        .ignored    (ignored),
        .table_full (table_full),
        .hit_score  (hit_score)
    );

    gnhs_verdict_checker #(
        .MAX_HITS (MAX_HITS),
        .POS_BITS (POS_BITS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_en         (cfg_en),
        .cfg_idx        (cfg_idx),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .first          (first),
        .start_a        (start_a),
        .end_a          (end_a),
        .start_b        (start_b),
        .end_b          (end_b),
        .cand_score     (cand_score),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .accepted       (accepted),
        .hit_slot       (hit_slot),
        .ignored        (ignored),
        .table_full     (table_full),
        .hit_score      (hit_score),
        .mismatch_count (mismatch_count),
        .verdicts_due   (verdicts_due)
    );

    // offer one candidate word and hold it until the block takes it
    task automatic offer_word(input bit f, input logic [15:0] sa, ea, sb, eb,
                              input logic [31:0] sc);
        int gap;
        gap = 0;
        // bursts of random length, random gaps in between
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1, 2:    gap = $urandom_range(1, 4);
                default: gap = $urandom_range(5, 30);
            endcase
        end
        burst_left--;
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        first      <= f;
        start_a    <= sa;
        end_a      <= ea;
        start_b    <= sb;
        end_b      <= eb;
        cand_score <= sc;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
    endtask

    // stop offering and wait for every verdict to come back
    task automatic drain_verdicts();
        @(negedge clk);
        in_valid <= 1'b0;
        while (verdicts_due != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_en   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
    endtask

    // registers only change with the block idle
    task automatic set_mode(input bit border, input logic [15:0] win, input int limit);
        logic [LIMIT_W-1:0] lim_bits;
        lim_bits = limit[LIMIT_W-1:0];
        drain_verdicts();
        cfg_write(REG_BORDER_MODE, {{(CFG_DATA_W-1){1'b0}}, border});
        cfg_write(REG_WINDOW, win);
        cfg_write(REG_HIT_LIMIT, {{(CFG_DATA_W-LIMIT_W){1'b0}}, lim_bits});
        @(negedge clk);
        cfg_en <= 1'b0;
    endtask

    // store MAX_HITS disjoint hits, then one more that finds no slot
    task automatic fill_hit_table(input bit border, input logic [15:0] win, input int limit);
        logic [15:0]        sa, sb;
        logic signed [31:0] sc;
        int                 k;
        set_mode(border, win, limit);
        sc = $urandom;
        for (k = 0; k < MAX_HITS; k++) begin
            // 250 apart, so no start falls inside a small window of another
            sa = 16'(k * 250 + $urandom_range(0, 100));
            sb = 16'(k * 250 + $urandom_range(0, 100));
            offer_word(k == 0, sa, 16'(sa + $urandom_range(0, 100)),
                       sb, 16'(sb + $urandom_range(0, 100)), sc);
            sc = sc - $urandom_range(0, 9);
        end
        offer_word(1'b0, FAR_LO, FAR_HI, FAR_LO, FAR_HI, sc);
    endtask

    // receiver: its own stall pattern, plus long hold-offs on request
    initial begin : receiver
        rx_pattern_t pattern;
        int          left;
        int          served;
        out_ready = 1'b0;
        pattern   = RX_OPEN;
        left      = 0;
        served    = 0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_requests > served) begin
                // sender keeps going meanwhile, block backs up
                served++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else begin
                if (left == 0) begin
                    pattern = rx_pattern_t'($urandom_range(0, 3));
                    left    = $urandom_range(8, 80);
                end
                left--;
                case (pattern)
                    RX_OPEN:  out_ready <= 1'b1;
                    RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
                    RX_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
                    default:  out_ready <= (left % 5 < 2);
                endcase
            end
        end
    end

    // watchdog: too long without any word moving ends the run
    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n);
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        int                 next_hold_at;
        int                 random_start;
        int                 seq_len;
        int                 span;
        int                 reach;
        int                 k;
        int                 limit;
        logic [15:0]        win;
        logic [15:0]        base_a, base_b;
        logic [15:0]        sa, ea, sb, eb, swap;
        logic signed [31:0] sc;

        rst_n      = 1'b0;
        cfg_en     = 1'b0;
        cfg_idx    = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        first      = 1'b0;
        start_a    = '0;
        end_a      = '0;
        start_b    = '0;
        end_b      = '0;
        cand_score = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // interval intersection, unlimited
        set_mode(1'b0, 16'h0000, -1);
        offer_word(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h7FFF_FFFF);
        // same hit again, overlaps in both
        offer_word(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
        offer_word(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h8000_0000);
        // overlaps only in the first sequence, kept
        offer_word(1'b0, 16'd0, 16'd10, 16'd100, 16'd200, 32'd900);
        offer_word(1'b0, 16'd5, 16'd5, 16'd150, 16'd150, 32'd800);
        // end before start
        offer_word(1'b0, 16'd30, 16'd20, 16'd300, 16'd250, 32'd700);
        offer_word(1'b0, 16'd20, 16'd30, 16'd250, 16'd300, 32'd600);

        // start window, no widening
        set_mode(1'b1, 16'h0000, -1);
        offer_word(1'b1, 16'd100, 16'd200, 16'd100, 16'd200, 32'd500);
        offer_word(1'b0, 16'd50, 16'd150, 16'd50, 16'd150, 32'd400);
        // kept start right on the border is not inside
        offer_word(1'b0, 16'd100, 16'd200, 16'd100, 16'd200, 32'd300);
        offer_word(1'b0, 16'd0, 16'd99, 16'd0, 16'd300, 32'd200);

        // widest window, lower bound goes below zero
        set_mode(1'b1, 16'hFFFF, -1);
        offer_word(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd100);
        offer_word(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd90);
        offer_word(1'b0, 16'd0, 16'd1, 16'd0, 16'd1, 32'd80);

        // limit zero: one hit, then ignored until first clears the count
        set_mode(1'b0, 16'h0000, 0);
        offer_word(1'b1, 16'd5, 16'd6, 16'd7, 16'd8, 32'd70);
        offer_word(1'b0, 16'd1000, 16'd1001, 16'd1000, 16'd1001, 32'd60);
        offer_word(1'b1, 16'd1000, 16'd1001, 16'd1000, 16'd1001, 32'd50);
        set_mode(1'b0, 16'h0000, 1);
        offer_word(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 32'd40);
        offer_word(1'b0, 16'd10, 16'd10, 16'd10, 16'd10, 32'd30);
        offer_word(1'b0, 16'd20, 16'd20, 16'd20, 16'd20, 32'd20);

        // full table at a limit of MAX_HITS, count sits at MAX_HITS
        fill_hit_table(1'b0, 16'h0000, MAX_HITS);
        offer_word(1'b0, FAR_LO, FAR_HI, FAR_LO, FAR_HI, 32'd10);
        // one below: the full count now exceeds the limit
        set_mode(1'b0, 16'h0000, MAX_HITS - 1);
        offer_word(1'b0, FAR_LO, FAR_HI, FAR_LO, FAR_HI, 32'd9);
        set_mode(1'b0, 16'h0000, -1);
        offer_word(1'b0, FAR_LO, FAR_HI, FAR_LO, FAR_HI, 32'd8);
        // first on a full table starts over at slot zero
        offer_word(1'b1, FAR_LO, FAR_HI, FAR_LO, FAR_HI, 32'd7);
        fill_hit_table(1'b1, 16'd15, -1);

        // random phases: a fresh setting, then runs of candidates that
        // usually open with first and stay in a narrow region so they collide often
        random_start = words_sent;
        next_hold_at = words_sent + 500;
        while (words_sent - random_start < RANDOM_WORDS) begin
            case ($urandom_range(0, 3))
                0:       win = 16'h0000;
                1:       win = 16'hFFFF;
                2:       win = 16'($urandom_range(1, 24));
                default: win = 16'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0:       limit = -1;
                1:       limit = MAX_HITS;
                2:       limit = $urandom_range(0, 3);
                3:       limit = $urandom_range(0, 20);
                default: limit = $urandom_range(0, MAX_HITS);
            endcase
            set_mode($urandom_range(0, 1) != 0, win, limit);
            repeat ($urandom_range(3, 12)) begin
                if (words_sent >= next_hold_at) begin
                    hold_requests++;
                    next_hold_at += 700;
                end
                seq_len = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 12);
                base_a = 16'($urandom_range(0, 64000));
                base_b = 16'($urandom_range(0, 64000));
                case ($urandom_range(0, 2))
                    0:       span = 3;
                    1:       span = 40;
                    default: span = 600;
                endcase
                reach = $urandom_range(0, span);
                sc    = $urandom;
                for (k = 0; k < seq_len; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        // noise: any value in any field
                        offer_word($urandom_range(0, 1) != 0, 16'($urandom), 16'($urandom),
                                   16'($urandom), 16'($urandom), $urandom);
                    end else begin
                        sa = 16'(base_a + $urandom_range(0, span));
                        ea = 16'(sa + $urandom_range(0, reach));
                        sb = 16'(base_b + $urandom_range(0, span));
                        eb = 16'(sb + $urandom_range(0, reach));
                        if ($urandom_range(0, 7) == 0) begin
                            swap = sa;
                            sa   = ea;
                            ea   = swap;
                        end
                        offer_word(k == 0, sa, ea, sb, eb, sc);
                        sc = sc - $urandom_range(0, 999);
                    end
                end
            end
        end

        drain_verdicts();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== greedy_nonoverlap_hit_selector_unit.f =====
src/gnhs_pkg.sv
src/gnhs_ctrl.sv
src/gnhs_datapath.sv
src/greedy_nonoverlap_hit_selector_unit.sv
dv/gnhs_verdict_checker.sv
dv/tb.sv
